>>> rtl/artnet_dmx_packet_filter_top_assert.svh
// ----------------------------------------------------------------------------
// artnet dmx packet filter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ARTNET_DMX_PACKET_FILTER_TOP_ASSERT_SVH
`define ARTNET_DMX_PACKET_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define ADPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/adpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpf_pkg
// types, constants and helpers shared by the art-net dmx filter modules
// ----------------------------------------------------------------------------
package adpf_pkg;

    localparam int MAX_DATAGRAM_BYTES = 2048;

    localparam logic [15:0] OPCODE_OUTPUT    = 16'h5000;
    localparam logic [15:0] OPCODE_POLL      = 16'h2000;
    localparam logic [15:0] PROTOCOL_VERSION = 16'd14;
    localparam logic [3:0]  NIBBLE_MASK      = 4'hF;

    // byte offsets inside the datagram
    localparam logic [10:0] OFS_ID_END      = 11'd8;
    localparam logic [10:0] OFS_OPCODE_LO   = 11'd8;
    localparam logic [10:0] OFS_OPCODE_HI   = 11'd9;
    localparam logic [10:0] OFS_VERSION_HI  = 11'd10;
    localparam logic [10:0] OFS_VERSION_LO  = 11'd11;
    localparam logic [10:0] OFS_TALK_TO_ME  = 11'd12;
    localparam logic [10:0] OFS_SUBUNI      = 11'd14;
    localparam logic [10:0] OFS_NET         = 11'd15;
    localparam logic [10:0] OFS_LENGTH_HI   = 11'd16;
    localparam logic [10:0] OFS_LENGTH_LO   = 11'd17;
    localparam logic [10:0] DATA_OFFSET     = 11'd18;

    // configuration register indexes
    localparam logic [1:0] REG_RECEIVE_ENABLE   = 2'd0;
    localparam logic [1:0] REG_NET_ADDRESS      = 2'd1;
    localparam logic [1:0] REG_SUBNET_ADDRESS   = 2'd2;
    localparam logic [1:0] REG_UNIVERSE_ADDRESS = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // event kinds
    localparam logic EVENT_DMX  = 1'b0;
    localparam logic EVENT_POLL = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       receive_enable;
        logic [6:0] net_address;
        logic [3:0] subnet_address;
        logic [3:0] universe_address;
    } cfg_t;

    typedef struct packed {
        logic        event_kind;
        logic [7:0]  byte_value;
        logic [10:0] channel_index;
        logic        last_of_frame;
    } event_rec_t;

    typedef struct packed {
        logic       valid;
        event_rec_t rec;
    } queue_head_t;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h41;
            3'd1:    val = 8'h72;
            3'd2:    val = 8'h74;
            3'd3:    val = 8'h2D;
            3'd4:    val = 8'h4E;
            3'd5:    val = 8'h65;
            3'd6:    val = 8'h74;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/adpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpf_front
// byte parser: tracks datagram position, checks header and classifies bytes
// ----------------------------------------------------------------------------
module adpf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  adpf_pkg::cfg_t      cfg,
    input  logic                take,
    input  logic [7:0]          payload_byte,
    input  logic                first_of_datagram,
    input  logic [10:0]         datagram_length,
    output logic                push,
    output adpf_pkg::event_rec_t push_rec
);

    localparam logic [16:0] MAX_LEN = 17'(adpf_pkg::MAX_DATAGRAM_BYTES);

    logic [10:0] byte_position_reg, byte_position_next;
    logic [10:0] frame_length_reg,  frame_length_next;
    logic        header_good_reg,   header_good_next;
    logic [15:0] opcode_reg,        opcode_next;
    logic [15:0] version_reg,       version_next;
    logic [7:0]  subuni_reg,        subuni_next;
    logic [7:0]  net_reg,           net_next;
    logic [15:0] dmx_length_reg,    dmx_length_next;

    logic [10:0] pos_cur;
    logic [10:0] flen_cur;
    logic        hg_cur;
    logic [15:0] opcode_cur;
    logic [15:0] version_cur;
    logic [7:0]  subuni_cur;
    logic [7:0]  net_cur;
    logic [15:0] dmx_cur;
    logic [10:0] idx;
    logic        addr_match;

    always_comb
    begin
        if (first_of_datagram)
        begin
            pos_cur     = '0;
            flen_cur    = ({6'd0, datagram_length} > MAX_LEN) ? MAX_LEN[10:0]
                                                              : datagram_length;
            hg_cur      = 1'b1;
            opcode_cur  = '0;
            version_cur = '0;
            subuni_cur  = '0;
            net_cur     = '0;
            dmx_cur     = '0;
        end
        else
        begin
            pos_cur     = byte_position_reg;
            flen_cur    = frame_length_reg;
            hg_cur      = header_good_reg;
            opcode_cur  = opcode_reg;
            version_cur = version_reg;
            subuni_cur  = subuni_reg;
            net_cur     = net_reg;
            dmx_cur     = dmx_length_reg;
        end
    end

    assign idx = pos_cur - adpf_pkg::DATA_OFFSET;

    assign addr_match = hg_cur
        && (opcode_cur == adpf_pkg::OPCODE_OUTPUT)
        && (version_cur == adpf_pkg::PROTOCOL_VERSION)
        && (net_cur == {1'b0, cfg.net_address})
        && ((subuni_cur[7:4] & adpf_pkg::NIBBLE_MASK) == cfg.subnet_address)
        && ((subuni_cur[3:0] & adpf_pkg::NIBBLE_MASK) == cfg.universe_address)
        && ({6'd0, flen_cur} >= ({6'd0, adpf_pkg::DATA_OFFSET} + {1'b0, dmx_cur}));

    always_comb
    begin
        byte_position_next = byte_position_reg;
        frame_length_next  = frame_length_reg;
        header_good_next   = header_good_reg;
        opcode_next        = opcode_reg;
        version_next       = version_reg;
        subuni_next        = subuni_reg;
        net_next           = net_reg;
        dmx_length_next    = dmx_length_reg;
        push               = 1'b0;
        push_rec           = '0;

        if (take)
        begin
            if (!cfg.receive_enable)
            begin
                // abandon the datagram in progress
                header_good_next   = 1'b0;
                byte_position_next = frame_length_reg;
            end
            else
            begin
                frame_length_next = flen_cur;
                header_good_next  = hg_cur;
                opcode_next       = opcode_cur;
                version_next      = version_cur;
                subuni_next       = subuni_cur;
                net_next          = net_cur;
                dmx_length_next   = dmx_cur;
                byte_position_next = pos_cur;

                if (pos_cur < flen_cur)
                begin
                    byte_position_next = pos_cur + 11'd1;
                    if (pos_cur < adpf_pkg::OFS_ID_END)
                    begin
                        if (payload_byte != adpf_pkg::id_byte(pos_cur[2:0]))
                        begin
                            header_good_next = 1'b0;
                        end
                    end
                    else
                    begin
                        unique case (pos_cur)
                            adpf_pkg::OFS_OPCODE_LO:
                                opcode_next = {8'h00, payload_byte};
                            adpf_pkg::OFS_OPCODE_HI:
                                opcode_next = {payload_byte, opcode_cur[7:0]};
                            adpf_pkg::OFS_VERSION_HI:
                                version_next = {payload_byte, 8'h00};
                            adpf_pkg::OFS_VERSION_LO:
                                version_next = {version_cur[15:8], payload_byte};
                            adpf_pkg::OFS_TALK_TO_ME:
                            begin
                                if (hg_cur && (opcode_cur == adpf_pkg::OPCODE_POLL))
                                begin
                                    push                   = 1'b1;
                                    push_rec.event_kind    = adpf_pkg::EVENT_POLL;
                                    push_rec.byte_value    = payload_byte;
                                    push_rec.channel_index = '0;
                                    push_rec.last_of_frame = 1'b1;
                                end
                            end
                            adpf_pkg::OFS_SUBUNI:
                                subuni_next = payload_byte;
                            adpf_pkg::OFS_NET:
                                net_next = payload_byte;
                            adpf_pkg::OFS_LENGTH_HI:
                                dmx_length_next = {payload_byte, 8'h00};
                            adpf_pkg::OFS_LENGTH_LO:
                                dmx_length_next = {dmx_cur[15:8], payload_byte};
                            default:
                            begin
                                if ((pos_cur >= adpf_pkg::DATA_OFFSET)
                                    && ({5'd0, idx} < dmx_cur) && addr_match)
                                begin
                                    push                   = 1'b1;
                                    push_rec.event_kind    = adpf_pkg::EVENT_DMX;
                                    push_rec.byte_value    = payload_byte;
                                    push_rec.channel_index = idx;
                                    push_rec.last_of_frame =
                                        (({6'd0, idx} + 17'd1) == {1'b0, dmx_cur});
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            frame_length_reg  <= '0;
            header_good_reg   <= 1'b0;
            opcode_reg        <= '0;
            version_reg       <= '0;
            subuni_reg        <= '0;
            net_reg           <= '0;
            dmx_length_reg    <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            frame_length_reg  <= frame_length_next;
            header_good_reg   <= header_good_next;
            opcode_reg        <= opcode_next;
            version_reg       <= version_next;
            subuni_reg        <= subuni_next;
            net_reg           <= net_next;
            dmx_length_reg    <= dmx_length_next;
        end
    end

endmodule

>>> rtl/adpf_queue.sv
`timescale 1ns / 1ps
`include "artnet_dmx_packet_filter_top_assert.svh"
// ----------------------------------------------------------------------------
// adpf_queue
// small event queue that decouples the parser from the output stage
// ----------------------------------------------------------------------------
module adpf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  adpf_pkg::event_rec_t push_rec,
    input  logic                 pop,
    output adpf_pkg::queue_head_t head,
    output logic                 full
);

    localparam logic [adpf_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        adpf_pkg::QUEUE_PTR_W'(adpf_pkg::QUEUE_DEPTH - 1);
    localparam logic [adpf_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        adpf_pkg::QUEUE_CNT_W'(adpf_pkg::QUEUE_DEPTH);

    adpf_pkg::event_rec_t entries_reg [adpf_pkg::QUEUE_DEPTH];

    logic [adpf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [adpf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [adpf_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == DEPTH_CNT);
    assign head.valid = (count_reg != '0);
    assign head.rec   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `ADPF_ASSERT_NOW(a_queue_no_overflow, push, !full, "event pushed into a full queue")
    `ADPF_ASSERT_NOW(a_queue_no_underflow, pop, head.valid, "event popped from an empty queue")
    `ADPF_ASSERT_NOW(a_queue_count_bound, 1'b1, count_reg <= DEPTH_CNT, "queue count past depth")

endmodule

>>> rtl/adpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpf_back
// output stage: moves queued events into the result register
// ----------------------------------------------------------------------------
module adpf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  adpf_pkg::queue_head_t head,
    output logic                  pop,
    input  logic                  out_ready,
    output logic                  out_valid,
    output adpf_pkg::event_rec_t  out_rec
);

    logic                 out_valid_reg, out_valid_next;
    adpf_pkg::event_rec_t out_rec_reg;

    assign pop = head.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_rec_reg <= head.rec;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

>>> rtl/artnet_dmx_packet_filter_top.sv
`timescale 1ns / 1ps
`include "artnet_dmx_packet_filter_top_assert.svh"
// ----------------------------------------------------------------------------
// artnet_dmx_packet_filter_top
// art-net receive filter: passes dmx data of the addressed universe and
// reports poll requests
//
// channel   handshake              payload
// in        in_valid / in_ready    payload_byte, first_of_datagram, datagram_length
// out       out_valid / out_ready  event_kind, byte_value, channel_index, last_of_frame
// cfg       cfg_write              cfg_index, cfg_data
//
// one byte accepted per cycle while in_ready is high; the parser classifies it in
// the cycle it is taken, writes its event into the queue at the accepting edge,
// and the event moves into the output register once that register is free
// a four-entry queue sits between parser and output register
// in_ready falls only when that queue is full
// asynchronous reset clears parser state, queue pointers, out_valid and config to their defaults
// ----------------------------------------------------------------------------
module artnet_dmx_packet_filter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [adpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [adpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        payload_byte,
    input  logic                              first_of_datagram,
    input  logic [10:0]                       datagram_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              event_kind,
    output logic [7:0]                        byte_value,
    output logic [10:0]                       channel_index,
    output logic                              last_of_frame
);

    adpf_pkg::cfg_t        cfg_reg, cfg_next;
    adpf_pkg::event_rec_t  push_rec;
    adpf_pkg::event_rec_t  out_rec;
    adpf_pkg::queue_head_t head;
    logic                  take;
    logic                  push;
    logic                  pop;
    logic                  full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                adpf_pkg::REG_RECEIVE_ENABLE:   cfg_next.receive_enable   = cfg_data[0];
                adpf_pkg::REG_NET_ADDRESS:      cfg_next.net_address      = cfg_data[6:0];
                adpf_pkg::REG_SUBNET_ADDRESS:   cfg_next.subnet_address   = cfg_data[3:0];
                adpf_pkg::REG_UNIVERSE_ADDRESS: cfg_next.universe_address = cfg_data[3:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.receive_enable   <= 1'b1;
            cfg_reg.net_address      <= '0;
            cfg_reg.subnet_address   <= '0;
            cfg_reg.universe_address <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    adpf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .take              (take),
        .payload_byte      (payload_byte),
        .first_of_datagram (first_of_datagram),
        .datagram_length   (datagram_length),
        .push              (push),
        .push_rec          (push_rec)
    );

    adpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .full     (full)
    );

    adpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_rec   (out_rec)
    );

    assign event_kind    = out_rec.event_kind;
    assign byte_value    = out_rec.byte_value;
    assign channel_index = out_rec.channel_index;
    assign last_of_frame = out_rec.last_of_frame;

    `ADPF_ASSERT_NOW(a_poll_shape, out_valid && (event_kind == adpf_pkg::EVENT_POLL),
        (channel_index == '0) && last_of_frame, "poll event with index or last mark wrong")
    `ADPF_ASSERT_NEXT(a_disabled_no_push, take && !cfg_reg.receive_enable,
        !$past(push), "event produced while receive disabled")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the art-net dmx receive filter: streams datagram
// bytes through the input channel under random idling, predicts dmx and poll
// events per accepted byte, and compares every output event in order
// ----------------------------------------------------------------------------

localparam logic [63:0] ART_NET_ID = 64'h4172_742D_4E65_7400;

typedef struct packed {
    logic [7:0]  payload_byte;
    logic        first_of_datagram;
    logic [10:0] datagram_length;
} dmx_req_t;

class artnet_event_model;
    adpf_pkg::cfg_t       rx_cfg;
    int                   byte_pos;
    int                   frame_len;
    logic                 id_ok;
    logic [15:0]          opcode;
    logic [15:0]          version;
    logic [7:0]           subuni;
    logic [7:0]           net_byte;
    logic [15:0]          dmx_len;
    adpf_pkg::event_rec_t expected_events[$];
    int                   error_count;

    function new();
        rx_cfg = '0;
        rx_cfg.receive_enable = 1'b1;
        error_count = 0;
        clear_datagram();
    endfunction

    function void clear_datagram();
        byte_pos = 0;
        frame_len = 0;
        id_ok = 1'b0;
        opcode = '0;
        version = '0;
        subuni = '0;
        net_byte = '0;
        dmx_len = '0;
    endfunction

    function void set_register(logic [adpf_pkg::CFG_INDEX_W-1:0] index,
                               logic [adpf_pkg::CFG_DATA_W-1:0] data);
        case (index)
            adpf_pkg::REG_RECEIVE_ENABLE:   rx_cfg.receive_enable = data[0];
            adpf_pkg::REG_NET_ADDRESS:      rx_cfg.net_address = data[6:0];
            adpf_pkg::REG_SUBNET_ADDRESS:   rx_cfg.subnet_address = data[3:0];
            adpf_pkg::REG_UNIVERSE_ADDRESS: rx_cfg.universe_address = data[3:0];
            default: ;
        endcase
    endfunction

    function bit frame_addressed();
        return id_ok && opcode == adpf_pkg::OPCODE_OUTPUT
            && version == adpf_pkg::PROTOCOL_VERSION
            && net_byte == {1'b0, rx_cfg.net_address}
            && subuni[7:4] == rx_cfg.subnet_address
            && subuni[3:0] == rx_cfg.universe_address
            && frame_len >= int'(adpf_pkg::DATA_OFFSET) + int'(dmx_len);
    endfunction

    function void take_byte(dmx_req_t r);
        int pos;
        int idx;
        if (!rx_cfg.receive_enable)
        begin
            id_ok = 1'b0;
            byte_pos = frame_len;
            return;
        end
        if (r.first_of_datagram)
        begin
            clear_datagram();
            frame_len = (int'(r.datagram_length) > adpf_pkg::MAX_DATAGRAM_BYTES) ?
                adpf_pkg::MAX_DATAGRAM_BYTES : int'(r.datagram_length);
            id_ok = 1'b1;
        end
        if (byte_pos >= frame_len)
            return;
        pos = byte_pos;
        byte_pos = pos + 1;
        if (pos < int'(adpf_pkg::OFS_ID_END))
        begin
            if (r.payload_byte != ART_NET_ID[63 - 8 * pos -: 8])
                id_ok = 1'b0;
            return;
        end
        case (pos)
            adpf_pkg::OFS_OPCODE_LO:  opcode = {8'h00, r.payload_byte};
            adpf_pkg::OFS_OPCODE_HI:  opcode = {r.payload_byte, opcode[7:0]};
            adpf_pkg::OFS_VERSION_HI: version = {r.payload_byte, 8'h00};
            adpf_pkg::OFS_VERSION_LO: version = {version[15:8], r.payload_byte};
            adpf_pkg::OFS_TALK_TO_ME:
            begin
                if (id_ok && opcode == adpf_pkg::OPCODE_POLL)
                    expected_events.push_back({adpf_pkg::EVENT_POLL, r.payload_byte,
                                               11'd0, 1'b1});
            end
            adpf_pkg::OFS_TALK_TO_ME + 11'd1: ;
            adpf_pkg::OFS_SUBUNI:     subuni = r.payload_byte;
            adpf_pkg::OFS_NET:        net_byte = r.payload_byte;
            adpf_pkg::OFS_LENGTH_HI:  dmx_len = {r.payload_byte, 8'h00};
            adpf_pkg::OFS_LENGTH_LO:  dmx_len = {dmx_len[15:8], r.payload_byte};
            default:
            begin
                idx = pos - int'(adpf_pkg::DATA_OFFSET);
                if (idx < int'(dmx_len) && frame_addressed())
                    expected_events.push_back({adpf_pkg::EVENT_DMX, r.payload_byte,
                                               11'(idx), 1'(idx + 1 == int'(dmx_len))});
            end
        endcase
    endfunction

    task report(string msg);
        error_count++;
        if (error_count <= 100)
            $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_event(adpf_pkg::event_rec_t seen);
        adpf_pkg::event_rec_t want;
        if (expected_events.size() == 0)
        begin
            report($sformatf("unexpected event kind %0d value %02h channel %0d last %0d",
                             seen.event_kind, seen.byte_value, seen.channel_index,
                             seen.last_of_frame));
            return;
        end
        want = expected_events.pop_front();
        if (seen.event_kind !== want.event_kind)
            report($sformatf("event_kind %0d, want %0d", seen.event_kind, want.event_kind));
        if (seen.byte_value !== want.byte_value)
            report($sformatf("byte_value %02h, want %02h", seen.byte_value, want.byte_value));
        if (seen.channel_index !== want.channel_index)
            report($sformatf("channel_index %0d, want %0d",
                             seen.channel_index, want.channel_index));
        if (seen.last_of_frame !== want.last_of_frame)
            report($sformatf("last_of_frame %0d, want %0d",
                             seen.last_of_frame, want.last_of_frame));
    endtask
endclass

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 12;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [adpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [adpf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [7:0]                       payload_byte = '0;
    logic                             first_of_datagram = 1'b0;
    logic [10:0]                      datagram_length = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             event_kind;
    logic [7:0]                       byte_value;
    logic [10:0]                      channel_index;
    logic                             last_of_frame;

    artnet_event_model event_model = new();
    dmx_req_t          req_stream[$];
    int                in_burst = 0;
    int                out_burst = 0;

    artnet_dmx_packet_filter_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .payload_byte      (payload_byte),
        .first_of_datagram (first_of_datagram),
        .datagram_length   (datagram_length),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .event_kind        (event_kind),
        .byte_value        (byte_value),
        .channel_index     (channel_index),
        .last_of_frame     (last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("artnet_dmx_packet_filter_top regression: fail");
        $finish;
    end

    function automatic int draw_gap(ref int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    task automatic load_register(logic [adpf_pkg::CFG_INDEX_W-1:0] index,
                                 logic [adpf_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        event_model.set_register(index, data);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_setting(logic enable, logic [6:0] net_sel, logic [3:0] subnet_sel,
                                 logic [3:0] universe_sel);
        load_register(adpf_pkg::REG_RECEIVE_ENABLE, {6'd0, enable});
        load_register(adpf_pkg::REG_NET_ADDRESS, net_sel);
        load_register(adpf_pkg::REG_SUBNET_ADDRESS, {3'd0, subnet_sel});
        load_register(adpf_pkg::REG_UNIVERSE_ADDRESS, {3'd0, universe_sel});
    endtask

    task automatic push_datagram(logic [15:0] opcode, logic [15:0] version, logic [7:0] subuni,
                                 logic [7:0] net_byte, logic [15:0] dmx_len, logic [7:0] talk,
                                 int sent, int declared);
        logic [7:0] dg[$];
        dmx_req_t   r;
        for (int i = 0; i < 8; i++)
            dg.push_back(ART_NET_ID[63 - 8 * i -: 8]);
        dg.push_back(opcode[7:0]);
        dg.push_back(opcode[15:8]);
        dg.push_back(version[15:8]);
        dg.push_back(version[7:0]);
        dg.push_back(talk);
        dg.push_back(8'($urandom));
        dg.push_back(subuni);
        dg.push_back(net_byte);
        dg.push_back(dmx_len[15:8]);
        dg.push_back(dmx_len[7:0]);
        while (dg.size() < sent)
            dg.push_back(8'($urandom));
        for (int i = 0; i < sent; i++)
        begin
            r.payload_byte = dg[i];
            r.first_of_datagram = (i == 0);
            r.datagram_length = (i == 0) ? 11'(declared) : 11'($urandom);
            req_stream.push_back(r);
        end
    endtask

    task automatic queue_random_datagram();
        int          kind;
        int          dlen;
        int          body;
        int          sent;
        int          declared;
        int          start;
        int          bad_id;
        logic [15:0] opcode;
        logic [15:0] version;
        logic [7:0]  subuni;
        logic [7:0]  net_byte;
        dmx_req_t    r;
        kind = $urandom_range(0, 99);
        opcode = adpf_pkg::OPCODE_OUTPUT;
        version = adpf_pkg::PROTOCOL_VERSION;
        subuni = {event_model.rx_cfg.subnet_address, event_model.rx_cfg.universe_address};
        net_byte = {1'b0, event_model.rx_cfg.net_address};
        dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        body = int'(adpf_pkg::DATA_OFFSET) + dlen;
        sent = body;
        declared = body;
        bad_id = -1;
        start = req_stream.size();
        if (kind < 45)
        begin
            case ($urandom_range(0, 5))
                0: sent = body + $urandom_range(1, 4);
                1:
                begin
                    declared = body + $urandom_range(1, 8);
                    sent = declared;
                end
                default: ;
            endcase
        end
        else if (kind < 57)
        begin
            case ($urandom_range(0, 5))
                0: bad_id = $urandom_range(0, 7);
                1: opcode ^= 16'(1) << $urandom_range(0, 15);
                2: version ^= 16'(1) << $urandom_range(0, 15);
                3: net_byte ^= 8'(1) << $urandom_range(0, 7);
                4: subuni ^= 8'(1) << $urandom_range(0, 3);
                default: subuni ^= 8'h10 << $urandom_range(0, 3);
            endcase
        end
        else if (kind < 70)
        begin
            opcode = adpf_pkg::OPCODE_POLL;
            version = 16'($urandom);
            if ($urandom_range(0, 5) == 0)
                bad_id = $urandom_range(0, 7);
            declared = $urandom_range(12, 16);
            sent = declared;
        end
        else if (kind < 76)
        begin
            opcode = 16'($urandom);
            declared = $urandom_range(1, 24);
            sent = declared;
        end
        else if (kind < 84)
        begin
            // truncated frame: datagram shorter than the dmx data it announces
            dlen = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535) :
                   ((dlen == 0) ? 1 : dlen);
            body = int'(adpf_pkg::DATA_OFFSET) + dlen;
            declared = $urandom_range(int'(adpf_pkg::DATA_OFFSET),
                                      (body - 1 < int'(adpf_pkg::DATA_OFFSET) + 30) ?
                                      body - 1 : int'(adpf_pkg::DATA_OFFSET) + 30);
            sent = declared;
        end
        else if (kind < 88)
        begin
            declared = 0;
            sent = $urandom_range(1, 6);
        end
        else if (kind < 94)
        begin
            // next datagram starts before this one is complete
            declared = $urandom_range(body, 2047);
            sent = $urandom_range(1, body);
        end
        else
        begin
            declared = $urandom_range(0, 2047);
            sent = $urandom_range(1, 30);
        end
        push_datagram(opcode, version, subuni, net_byte, 16'(dlen), 8'($urandom), sent,
                      declared);
        if (bad_id >= 0 && bad_id < sent)
        begin
            r = req_stream[start + bad_id];
            r.payload_byte ^= 8'(1) << $urandom_range(0, 7);
            req_stream[start + bad_id] = r;
        end
        if (kind >= 94)
        begin
            for (int i = start; i < req_stream.size(); i++)
            begin
                r = req_stream[i];
                r.payload_byte = 8'($urandom);
                if (i == start && $urandom_range(0, 1) == 0)
                    r.first_of_datagram = 1'b0;
                req_stream[i] = r;
            end
        end
    endtask

    task automatic send_request(dmx_req_t r);
        int gap;
        gap = draw_gap(in_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            payload_byte <= 8'($urandom);
            first_of_datagram <= 1'($urandom);
            datagram_length <= 11'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        payload_byte <= r.payload_byte;
        first_of_datagram <= r.first_of_datagram;
        datagram_length <= r.datagram_length;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        event_model.take_byte(r);
    endtask

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if (req_stream.size() == 0)
                queue_random_datagram();
            send_request(req_stream.pop_front());
        end
        in_valid <= 1'b0;
        while (event_model.expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : output_side
        int stall;
        forever
        begin
            stall = draw_gap(out_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            event_model.check_event({event_kind, byte_value, channel_index, last_of_frame});
        end
    end

    initial
    begin : input_side
        dmx_req_t r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        apply_setting(1'b1, 7'd0, 4'd0, 4'd0);

        // bytes with no datagram open
        r = {8'hFF, 1'b0, 11'h7FF};
        req_stream.push_back(r);
        r = {8'h00, 1'b0, 11'h000};
        req_stream.push_back(r);
        // poll request, zero-length datagram, one-channel dmx frame
        push_datagram(adpf_pkg::OPCODE_POLL, adpf_pkg::PROTOCOL_VERSION, 8'h00, 8'h00, 16'd0,
                      8'hFF, 13, 13);
        push_datagram(adpf_pkg::OPCODE_OUTPUT, adpf_pkg::PROTOCOL_VERSION, 8'h00, 8'h00,
                      16'd0, 8'h00, 1, 0);
        push_datagram(adpf_pkg::OPCODE_OUTPUT, adpf_pkg::PROTOCOL_VERSION, 8'h00, 8'h00,
                      16'd1, 8'h00, 19, 19);
        run_phase(req_stream.size());

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_setting(1'b1, 7'd127, 4'd15, 4'd15);
                1: apply_setting(1'b1, 7'd0, 4'd0, 4'd0);
                2: apply_setting(1'b0, 7'($urandom), 4'($urandom), 4'($urandom));
                3: apply_setting(1'b1, 7'd0, 4'd15, 4'd0);
                4: apply_setting(1'b1, 7'd127, 4'd0, 4'd15);
                default: apply_setting(1'b1, 7'($urandom), 4'($urandom), 4'($urandom));
            endcase
            run_phase(event_model.rx_cfg.receive_enable ? 110 : 40);
        end

        if (event_model.error_count == 0)
            $display("artnet_dmx_packet_filter_top regression: pass");
        else
            $display("artnet_dmx_packet_filter_top regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/adpf_pkg.sv
rtl/adpf_front.sv
rtl/adpf_queue.sv
rtl/adpf_back.sv
rtl/artnet_dmx_packet_filter_top.sv
verif/testbench.sv
